// ===== rtl/gtm_pkg.sv =====
// Shared types and constants for the gamepad to mouse mapper.
// Used by every module of the block; depends on nothing.
package gtm_pkg;

    // Configuration port
    localparam int ADDR_W = 4;
    localparam int DATA_W = 32;

    typedef enum logic [1:0] {
        REG_DEAD_ZONE = 2'd0,
        REG_TRIG_LVL  = 2'd1,
        REG_SPEED     = 2'd2
    } reg_idx_t;

    localparam logic [14:0]       DEAD_ZONE_RST = 15'd4096;
    localparam logic signed [7:0] TRIG_LVL_RST  = 8'sd64;
    localparam logic [4:0]        SPEED_RST     = 5'd4;

    // Input opcodes
    typedef enum logic [2:0] {
        OP_STICK  = 3'd0,
        OP_TRIG   = 3'd1,
        OP_MOD    = 3'd2,
        OP_ACTIVE = 3'd3,
        OP_TICK   = 3'd4
    } op_t;

    // Result kinds
    typedef enum logic [1:0] {
        EV_BUTTON = 2'd0,
        EV_MOVE   = 2'd1,
        EV_SCROLL = 2'd2
    } ev_t;

    // Stick axis handling
    localparam logic signed [15:0] AXIS_MIN = 16'sh8000;
    localparam logic signed [15:0] Y_CLAMP  = 16'sh8001;
    localparam int                 RAD_W    = 15;

    // Square root unit: one result bit per cycle
    localparam int               ROOT_W     = 8;
    localparam int               SQ_W       = 2 * ROOT_W;
    localparam int               ROOT_CNT_W = 3;
    localparam logic [ROOT_W-1:0]     ROOT_TOP  = 8'h80;
    localparam logic [ROOT_CNT_W-1:0] ROOT_LAST = 3'd7;

    // Divider: one quotient bit per cycle
    localparam int                   DIV_W     = 12;
    localparam int                   DIV_CNT_W = 4;
    localparam logic [DIV_CNT_W-1:0] DIV_LAST  = 4'd11;

    // Tick arithmetic
    localparam logic [4:0]  SPEED_MAX   = 5'd16;
    localparam logic [5:0]  DIV_BASE    = 6'd32;
    localparam logic [11:0] MOVE_NUM_K  = 12'd5;
    localparam logic [11:0] SCRL_NUM_K  = 12'd100;
    localparam logic [11:0] SCRL_DEN_K  = 12'd20;
    localparam logic [5:0]  SCROLL_STEP = 6'd20;
    localparam logic [4:0]  DELAY_MIN   = 5'd5;
    localparam logic [4:0]  DELAY_MAX   = 5'd20;

    typedef enum logic [1:0] {
        DSEL_X     = 2'd0,
        DSEL_Y     = 2'd1,
        DSEL_DELAY = 2'd2
    } div_sel_t;

    typedef enum logic [1:0] {
        OSEL_BTN_L = 2'd0,
        OSEL_BTN_R = 2'd1,
        OSEL_TICK  = 2'd2
    } out_sel_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_SQX_GO,
        S_SQX_WAIT,
        S_SQY_GO,
        S_SQY_WAIT,
        S_BTN_L,
        S_BTN_R,
        S_COMMIT,
        S_DX_GO,
        S_DX_WAIT,
        S_DY_GO,
        S_DY_WAIT,
        S_DD_GO,
        S_DD_WAIT,
        S_EMIT_TICK
    } state_t;

    typedef struct packed {
        logic     load_in;
        logic     sqrt_start;
        logic     sqrt_sel_y;
        logic     store_vx;
        logic     store_vy;
        logic     div_start;
        div_sel_t div_sel;
        logic     div_store;
        logic     out_load;
        out_sel_t out_sel;
        logic     out_last;
        logic     commit;
    } cmd_t;

    typedef struct packed {
        op_t  op;
        logic flag;
        logic chg_left;
        logic chg_right;
        logic tick_go;
        logic scroll_mode;
        logic sqrt_busy;
        logic div_busy;
        logic out_free;
    } stat_t;

endpackage

// ===== rtl/gtm_sqrt.sv =====
// Iterative integer square root, one root bit per cycle (MSB first).
// Depends on gtm_pkg for widths.
module gtm_sqrt (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [gtm_pkg::RAD_W-1:0]    radicand,
    output logic                         busy,
    output logic [gtm_pkg::ROOT_W-1:0]   root
);

    logic [gtm_pkg::RAD_W-1:0]      rad_reg,  rad_next;
    logic [gtm_pkg::ROOT_W-1:0]     root_reg, root_next;
    logic [gtm_pkg::ROOT_CNT_W-1:0] step_reg, step_next;
    logic                           busy_reg, busy_next;

    logic [gtm_pkg::ROOT_W-1:0] trial;
    logic [gtm_pkg::SQ_W-1:0]   trial_w;
    logic [gtm_pkg::SQ_W-1:0]   trial_sq;
    logic                       fits;

    assign trial    = root_reg | (gtm_pkg::ROOT_TOP >> step_reg);
    assign trial_w  = {{gtm_pkg::ROOT_W{1'b0}}, trial};
    assign trial_sq = trial_w * trial_w;
    assign fits     = trial_sq <= {{(gtm_pkg::SQ_W - gtm_pkg::RAD_W){1'b0}}, rad_reg};

    always_comb
    begin
        rad_next  = rad_reg;
        root_next = root_reg;
        step_next = step_reg;
        busy_next = busy_reg;
        if (start)
        begin
            rad_next  = radicand;
            root_next = '0;
            step_next = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (fits)
                root_next = trial;
            step_next = step_reg + 1'b1;
            if (step_reg == gtm_pkg::ROOT_LAST)
                busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rad_reg  <= rad_next;
        root_reg <= root_next;
    end

    assign busy = busy_reg;
    assign root = root_reg;

endmodule

// ===== rtl/gtm_div.sv =====
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on gtm_pkg for widths.
module gtm_div (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [gtm_pkg::DIV_W-1:0]   dividend,
    input  logic [gtm_pkg::DIV_W-1:0]   divisor,
    output logic                        busy,
    output logic [gtm_pkg::DIV_W-1:0]   quotient
);

    logic [gtm_pkg::DIV_W-1:0]     rem_reg, rem_next;
    logic [gtm_pkg::DIV_W-1:0]     quo_reg, quo_next;
    logic [gtm_pkg::DIV_W-1:0]     den_reg, den_next;
    logic [gtm_pkg::DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic                          busy_reg, busy_next;

    logic [gtm_pkg::DIV_W:0] shifted;
    logic [gtm_pkg::DIV_W:0] diff;
    logic                    ge;

    // Bring down the next dividend bit and try a subtract
    assign shifted = {rem_reg, quo_reg[gtm_pkg::DIV_W-1]};
    assign ge      = shifted >= {1'b0, den_reg};
    assign diff    = shifted - {1'b0, den_reg};

    always_comb
    begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        if (start)
        begin
            rem_next  = '0;
            quo_next  = dividend;
            den_next  = divisor;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next = ge ? diff[gtm_pkg::DIV_W-1:0] : shifted[gtm_pkg::DIV_W-1:0];
            quo_next = {quo_reg[gtm_pkg::DIV_W-2:0], ge};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == gtm_pkg::DIV_LAST)
                busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        den_reg <= den_next;
    end

    assign busy     = busy_reg;
    assign quotient = quo_reg;

endmodule

// ===== rtl/gtm_datapath.sv =====
// Datapath: item latch, mapper state, square root and divider units, result register.
// Depends on gtm_pkg, gtm_sqrt and gtm_div; driven by gtm_ctrl commands.
module gtm_datapath (
    input  logic                 clk,
    input  logic                 rst_n,
    input  gtm_pkg::cmd_t        cmd,
    output gtm_pkg::stat_t       stat,
    input  logic [2:0]           opcode,
    input  logic signed [15:0]   stick_x,
    input  logic signed [15:0]   stick_y,
    input  logic signed [7:0]    trigger_left,
    input  logic signed [7:0]    trigger_right,
    input  logic                 flag,
    input  logic [14:0]          dead_zone,
    input  logic signed [7:0]    trigger_level,
    input  logic [4:0]           speed,
    input  logic                 out_ready,
    output logic                 out_valid,
    output logic [1:0]           event_kind,
    output logic                 button_id,
    output logic                 button_pressed,
    output logic signed [4:0]    move_x,
    output logic signed [4:0]    move_y,
    output logic signed [5:0]    scroll_amount,
    output logic [4:0]           next_delay_ms,
    output logic                 last
);

    // Latched item
    gtm_pkg::op_t       op_reg;
    logic signed [15:0] sx_reg, sy_reg;
    logic signed [7:0]  tl_reg, tr_reg;
    logic               flag_reg;

    // Mapper state
    logic              active_reg, active_next;
    logic signed [8:0] vx_reg, vx_next;
    logic signed [8:0] vy_reg, vy_next;
    logic              left_reg, left_next;
    logic              right_reg, right_next;
    logic              scroll_reg, scroll_next;

    // Tick results
    logic [3:0] qx_reg, qx_next;
    logic [3:0] qy_reg, qy_next;
    logic [4:0] dly_reg, dly_next;

    // Result register
    logic              ovalid_reg, ovalid_next;
    gtm_pkg::ev_t      kind_reg, kind_next;
    logic              id_reg, id_next;
    logic              press_reg, press_next;
    logic signed [4:0] mx_reg, mx_next;
    logic signed [4:0] my_reg, my_next;
    logic signed [5:0] sc_reg, sc_next;
    logic [4:0]        odly_reg, odly_next;
    logic              last_reg, last_next;

    // Stick axis to square root operand
    logic [15:0]                 x_abs, y_abs;
    logic signed [15:0]          y_cl;
    logic [gtm_pkg::RAD_W-1:0]   mag, radicand;
    logic                        kill, neg;
    logic                        sqrt_busy;
    logic [gtm_pkg::ROOT_W-1:0]  root;
    logic signed [8:0]           axis_val;

    assign x_abs    = sx_reg[15] ? (16'd0 - sx_reg) : sx_reg;
    assign y_cl     = (sy_reg == gtm_pkg::AXIS_MIN) ? gtm_pkg::Y_CLAMP : sy_reg;
    assign y_abs    = y_cl[15] ? (16'd0 - y_cl) : y_cl;
    assign mag      = cmd.sqrt_sel_y ? y_abs[gtm_pkg::RAD_W-1:0] : x_abs[gtm_pkg::RAD_W-1:0];
    assign kill     = (mag < dead_zone) ||
                      (!cmd.sqrt_sel_y && (sx_reg == gtm_pkg::AXIS_MIN));
    // y takes the inverted sign after the root, so a positive raw y gives a negative result
    assign neg      = cmd.sqrt_sel_y ? !y_cl[15] : sx_reg[15];
    assign radicand = mag - dead_zone;
    assign axis_val = kill ? 9'sd0 : (neg ? (9'sd0 - $signed({1'b0, root})) :
                                            $signed({1'b0, root}));

    gtm_sqrt u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.sqrt_start),
        .radicand (radicand),
        .busy     (sqrt_busy),
        .root     (root)
    );

    // Triggers: new button levels, forced to release on deactivation
    logic ld, rd, new_left, new_right;

    assign ld        = tl_reg > trigger_level;
    assign rd        = tr_reg > trigger_level;
    assign new_left  = (op_reg == gtm_pkg::OP_TRIG) ? ld : 1'b0;
    assign new_right = (op_reg == gtm_pkg::OP_TRIG) ? rd : 1'b0;

    // Tick operands
    logic [7:0]  ax, ay;
    logic [4:0]  sp;
    logic [5:0]  dv;
    logic [11:0] d12, ax12, ay12, ax20, m_move, m_scroll;
    logic [11:0] dividend, divisor, quotient;
    logic        div_busy;
    logic [4:0]  delay_cl;

    assign ax       = vx_reg[8] ? 8'(9'd0 - vx_reg) : 8'(vx_reg);
    assign ay       = vy_reg[8] ? 8'(9'd0 - vy_reg) : 8'(vy_reg);
    assign sp       = (speed > gtm_pkg::SPEED_MAX) ? gtm_pkg::SPEED_MAX : speed;
    assign dv       = gtm_pkg::DIV_BASE - {1'b0, sp};
    assign d12      = 12'(dv);
    assign ax12     = 12'(ax);
    assign ay12     = 12'(ay);
    assign ax20     = ax12 * gtm_pkg::SCRL_DEN_K;
    assign m_move   = (ax12 > ay12) ? ax12 : ay12;
    assign m_scroll = (ax20 > ay12) ? ax20 : ay12;

    always_comb
    begin
        case (cmd.div_sel)
            gtm_pkg::DSEL_X:
            begin
                dividend = ax12;
                divisor  = d12;
            end
            gtm_pkg::DSEL_Y:
            begin
                dividend = ay12;
                divisor  = d12;
            end
            gtm_pkg::DSEL_DELAY:
            begin
                dividend = scroll_reg ? d12 * gtm_pkg::SCRL_NUM_K : d12 * gtm_pkg::MOVE_NUM_K;
                divisor  = scroll_reg ? m_scroll : m_move;
            end
            default:
            begin
                dividend = ax12;
                divisor  = d12;
            end
        endcase
    end

    gtm_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (dividend),
        .divisor  (divisor),
        .busy     (div_busy),
        .quotient (quotient)
    );

    assign delay_cl = (quotient < 12'(gtm_pkg::DELAY_MIN)) ? gtm_pkg::DELAY_MIN :
                      (quotient > 12'(gtm_pkg::DELAY_MAX)) ? gtm_pkg::DELAY_MAX :
                      quotient[4:0];

    // Step per axis: the quotient, at least one for a nonzero axis value
    logic [3:0] mag_x, mag_y;

    assign mag_x = (qx_reg == 4'd0 && ax != 8'd0) ? 4'd1 : qx_reg;
    assign mag_y = (qy_reg == 4'd0 && ay != 8'd0) ? 4'd1 : qy_reg;

    always_comb
    begin
        qx_next  = qx_reg;
        qy_next  = qy_reg;
        dly_next = dly_reg;
        if (cmd.div_store)
        begin
            case (cmd.div_sel)
                gtm_pkg::DSEL_X:     qx_next  = quotient[3:0];
                gtm_pkg::DSEL_Y:     qy_next  = quotient[3:0];
                gtm_pkg::DSEL_DELAY: dly_next = delay_cl;
                default:             dly_next = delay_cl;
            endcase
        end
    end

    // Mapper state update
    always_comb
    begin
        active_next = active_reg;
        vx_next     = vx_reg;
        vy_next     = vy_reg;
        left_next   = left_reg;
        right_next  = right_reg;
        scroll_next = scroll_reg;
        if (cmd.store_vx)
            vx_next = axis_val;
        if (cmd.store_vy)
            vy_next = axis_val;
        if (cmd.commit)
        begin
            case (op_reg)
                gtm_pkg::OP_TRIG:
                begin
                    left_next  = new_left;
                    right_next = new_right;
                end
                gtm_pkg::OP_MOD:
                    scroll_next = flag_reg;
                gtm_pkg::OP_ACTIVE:
                begin
                    active_next = flag_reg;
                    if (!flag_reg)
                    begin
                        vx_next    = '0;
                        vy_next    = '0;
                        left_next  = 1'b0;
                        right_next = 1'b0;
                    end
                end
                default:
                    scroll_next = scroll_reg;
            endcase
        end
    end

    // Result register
    always_comb
    begin
        ovalid_next = ovalid_reg;
        kind_next   = kind_reg;
        id_next     = id_reg;
        press_next  = press_reg;
        mx_next     = mx_reg;
        my_next     = my_reg;
        sc_next     = sc_reg;
        odly_next   = odly_reg;
        last_next   = last_reg;
        if (out_ready)
            ovalid_next = 1'b0;
        if (cmd.out_load)
        begin
            ovalid_next = 1'b1;
            last_next   = cmd.out_last;
            kind_next   = gtm_pkg::EV_BUTTON;
            id_next     = 1'b0;
            press_next  = 1'b0;
            mx_next     = '0;
            my_next     = '0;
            sc_next     = '0;
            odly_next   = '0;
            case (cmd.out_sel)
                gtm_pkg::OSEL_BTN_L:
                    press_next = new_left;
                gtm_pkg::OSEL_BTN_R:
                begin
                    id_next    = 1'b1;
                    press_next = new_right;
                end
                gtm_pkg::OSEL_TICK:
                begin
                    odly_next = dly_reg;
                    if (scroll_reg)
                    begin
                        kind_next = gtm_pkg::EV_SCROLL;
                        if (vy_reg > 9'sd0)
                            sc_next = 6'd0 - gtm_pkg::SCROLL_STEP;
                        else if (vy_reg < 9'sd0)
                            sc_next = gtm_pkg::SCROLL_STEP;
                    end
                    else
                    begin
                        kind_next = gtm_pkg::EV_MOVE;
                        mx_next   = vx_reg[8] ? (5'd0 - {1'b0, mag_x}) : {1'b0, mag_x};
                        my_next   = vy_reg[8] ? (5'd0 - {1'b0, mag_y}) : {1'b0, mag_y};
                    end
                end
                default:
                    press_next = 1'b0;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            vx_reg     <= '0;
            vy_reg     <= '0;
            left_reg   <= 1'b0;
            right_reg  <= 1'b0;
            scroll_reg <= 1'b0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            active_reg <= active_next;
            vx_reg     <= vx_next;
            vy_reg     <= vy_next;
            left_reg   <= left_next;
            right_reg  <= right_next;
            scroll_reg <= scroll_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            op_reg   <= gtm_pkg::op_t'(opcode);
            sx_reg   <= stick_x;
            sy_reg   <= stick_y;
            tl_reg   <= trigger_left;
            tr_reg   <= trigger_right;
            flag_reg <= flag;
        end
        qx_reg    <= qx_next;
        qy_reg    <= qy_next;
        dly_reg   <= dly_next;
        kind_reg  <= kind_next;
        id_reg    <= id_next;
        press_reg <= press_next;
        mx_reg    <= mx_next;
        my_reg    <= my_next;
        sc_reg    <= sc_next;
        odly_reg  <= odly_next;
        last_reg  <= last_next;
    end

    assign stat.op          = op_reg;
    assign stat.flag        = flag_reg;
    assign stat.chg_left    = new_left != left_reg;
    assign stat.chg_right   = new_right != right_reg;
    assign stat.tick_go     = active_reg && (vx_reg != 9'sd0 || vy_reg != 9'sd0);
    assign stat.scroll_mode = scroll_reg;
    assign stat.sqrt_busy   = sqrt_busy;
    assign stat.div_busy    = div_busy;
    assign stat.out_free    = !ovalid_reg || out_ready;

    assign out_valid      = ovalid_reg;
    assign event_kind     = kind_reg;
    assign button_id      = id_reg;
    assign button_pressed = press_reg;
    assign move_x         = mx_reg;
    assign move_y         = my_reg;
    assign scroll_amount  = sc_reg;
    assign next_delay_ms  = odly_reg;
    assign last           = last_reg;

endmodule

// ===== rtl/gtm_ctrl.sv =====
// Controller state machine: sequences one item through the datapath.
// Depends on gtm_pkg for state, command and status types.
module gtm_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  gtm_pkg::stat_t stat,
    output gtm_pkg::cmd_t  cmd
);

    gtm_pkg::state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            gtm_pkg::S_IDLE:
                if (in_valid)
                    state_next = gtm_pkg::S_DECODE;
            gtm_pkg::S_DECODE:
            begin
                case (stat.op)
                    gtm_pkg::OP_STICK:  state_next = gtm_pkg::S_SQX_GO;
                    gtm_pkg::OP_TRIG:   state_next = gtm_pkg::S_BTN_L;
                    gtm_pkg::OP_MOD:    state_next = gtm_pkg::S_COMMIT;
                    gtm_pkg::OP_ACTIVE:
                        state_next = stat.flag ? gtm_pkg::S_COMMIT : gtm_pkg::S_BTN_L;
                    gtm_pkg::OP_TICK:
                        if (!stat.tick_go)
                            state_next = gtm_pkg::S_IDLE;
                        else if (stat.scroll_mode)
                            state_next = gtm_pkg::S_DD_GO;
                        else
                            state_next = gtm_pkg::S_DX_GO;
                    default:            state_next = gtm_pkg::S_IDLE;
                endcase
            end
            gtm_pkg::S_SQX_GO:
                state_next = gtm_pkg::S_SQX_WAIT;
            gtm_pkg::S_SQX_WAIT:
                if (!stat.sqrt_busy)
                    state_next = gtm_pkg::S_SQY_GO;
            gtm_pkg::S_SQY_GO:
                state_next = gtm_pkg::S_SQY_WAIT;
            gtm_pkg::S_SQY_WAIT:
                if (!stat.sqrt_busy)
                    state_next = gtm_pkg::S_IDLE;
            gtm_pkg::S_BTN_L:
                if (!stat.chg_left || stat.out_free)
                    state_next = gtm_pkg::S_BTN_R;
            gtm_pkg::S_BTN_R:
                if (!stat.chg_right || stat.out_free)
                    state_next = gtm_pkg::S_COMMIT;
            gtm_pkg::S_COMMIT:
                state_next = gtm_pkg::S_IDLE;
            gtm_pkg::S_DX_GO:
                state_next = gtm_pkg::S_DX_WAIT;
            gtm_pkg::S_DX_WAIT:
                if (!stat.div_busy)
                    state_next = gtm_pkg::S_DY_GO;
            gtm_pkg::S_DY_GO:
                state_next = gtm_pkg::S_DY_WAIT;
            gtm_pkg::S_DY_WAIT:
                if (!stat.div_busy)
                    state_next = gtm_pkg::S_DD_GO;
            gtm_pkg::S_DD_GO:
                state_next = gtm_pkg::S_DD_WAIT;
            gtm_pkg::S_DD_WAIT:
                if (!stat.div_busy)
                    state_next = gtm_pkg::S_EMIT_TICK;
            gtm_pkg::S_EMIT_TICK:
                if (stat.out_free)
                    state_next = gtm_pkg::S_IDLE;
            default:
                state_next = gtm_pkg::S_IDLE;
        endcase
    end

    always_comb
    begin
        in_ready       = 1'b0;
        cmd            = '0;
        cmd.div_sel    = gtm_pkg::DSEL_X;
        cmd.out_sel    = gtm_pkg::OSEL_TICK;
        case (state_reg)
            gtm_pkg::S_IDLE:
            begin
                in_ready    = 1'b1;
                cmd.load_in = in_valid;
            end
            gtm_pkg::S_SQX_GO:
                cmd.sqrt_start = 1'b1;
            gtm_pkg::S_SQX_WAIT:
                cmd.store_vx = !stat.sqrt_busy;
            gtm_pkg::S_SQY_GO:
            begin
                cmd.sqrt_start = 1'b1;
                cmd.sqrt_sel_y = 1'b1;
            end
            gtm_pkg::S_SQY_WAIT:
            begin
                cmd.sqrt_sel_y = 1'b1;
                cmd.store_vy   = !stat.sqrt_busy;
            end
            gtm_pkg::S_BTN_L:
            begin
                // left is the final item only when right does not change
                cmd.out_sel  = gtm_pkg::OSEL_BTN_L;
                cmd.out_last = !stat.chg_right;
                cmd.out_load = stat.chg_left && stat.out_free;
            end
            gtm_pkg::S_BTN_R:
            begin
                cmd.out_sel  = gtm_pkg::OSEL_BTN_R;
                cmd.out_last = 1'b1;
                cmd.out_load = stat.chg_right && stat.out_free;
            end
            gtm_pkg::S_COMMIT:
                cmd.commit = 1'b1;
            gtm_pkg::S_DX_GO:
                cmd.div_start = 1'b1;
            gtm_pkg::S_DX_WAIT:
                cmd.div_store = !stat.div_busy;
            gtm_pkg::S_DY_GO:
            begin
                cmd.div_sel   = gtm_pkg::DSEL_Y;
                cmd.div_start = 1'b1;
            end
            gtm_pkg::S_DY_WAIT:
            begin
                cmd.div_sel   = gtm_pkg::DSEL_Y;
                cmd.div_store = !stat.div_busy;
            end
            gtm_pkg::S_DD_GO:
            begin
                cmd.div_sel   = gtm_pkg::DSEL_DELAY;
                cmd.div_start = 1'b1;
            end
            gtm_pkg::S_DD_WAIT:
            begin
                cmd.div_sel   = gtm_pkg::DSEL_DELAY;
                cmd.div_store = !stat.div_busy;
            end
            gtm_pkg::S_EMIT_TICK:
            begin
                cmd.out_sel  = gtm_pkg::OSEL_TICK;
                cmd.out_last = 1'b1;
                cmd.out_load = stat.out_free;
            end
            default:
                in_ready = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= gtm_pkg::S_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

// ===== rtl/gamepad_to_mouse_mapper_core.sv =====
// Gamepad to mouse mapper: takes one item at a time and turns stick, trigger, modifier,
// activation and tick items into button, pointer move and scroll results. A single
// result register sits on the output, so the next item is taken while the last result
// waits. Per item: a stick update runs two 8-step square roots, one per axis; a tick in
// pointer mode runs three 12-step divisions on one shared divider (x step, y step,
// delay); a tick in scroll mode runs the delay division only. A trigger update or a
// deactivation passes through the left and right button states before the commit; a
// modifier change or an activation goes straight to the commit; an unused opcode or a
// tick that emits nothing returns to idle. Button and tick results may wait for the
// result register to drain. Registers sit on the APB port at 0x0 dead_zone, 0x4
// trigger_level and 0x8 speed, and should be written only while the block is idle.
// Depends on gtm_pkg, gtm_ctrl and gtm_datapath.
module gamepad_to_mouse_mapper_core (
    input  logic                          clk,
    input  logic                          rst_n,
    // APB configuration port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [gtm_pkg::ADDR_W-1:0]    paddr,
    input  logic [gtm_pkg::DATA_W-1:0]    pwdata,
    output logic [gtm_pkg::DATA_W-1:0]    prdata,
    output logic                          pready,
    // Input items
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [2:0]                    opcode,
    input  logic signed [15:0]            stick_x,
    input  logic signed [15:0]            stick_y,
    input  logic signed [7:0]             trigger_left,
    input  logic signed [7:0]             trigger_right,
    input  logic                          flag,
    // Result items
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [1:0]                    event_kind,
    output logic                          button_id,
    output logic                          button_pressed,
    output logic signed [4:0]             move_x,
    output logic signed [4:0]             move_y,
    output logic signed [5:0]             scroll_amount,
    output logic [4:0]                    next_delay_ms,
    output logic                          last
);

    logic [14:0]       dz_reg, dz_next;
    logic signed [7:0] tl_reg, tl_next;
    logic [4:0]        spd_reg, spd_next;
    logic              wr_en;
    gtm_pkg::reg_idx_t wr_idx;

    gtm_pkg::cmd_t  cmd;
    gtm_pkg::stat_t stat;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;
    assign wr_idx = gtm_pkg::reg_idx_t'(paddr[3:2]);

    always_comb
    begin
        dz_next  = dz_reg;
        tl_next  = tl_reg;
        spd_next = spd_reg;
        if (wr_en)
        begin
            case (wr_idx)
                gtm_pkg::REG_DEAD_ZONE: dz_next  = pwdata[14:0];
                gtm_pkg::REG_TRIG_LVL:  tl_next  = pwdata[7:0];
                gtm_pkg::REG_SPEED:     spd_next = pwdata[4:0];
                default:                dz_next  = dz_reg;
            endcase
        end
    end

    always_comb
    begin
        case (wr_idx)
            gtm_pkg::REG_DEAD_ZONE: prdata = {17'd0, dz_reg};
            gtm_pkg::REG_TRIG_LVL:  prdata = {24'd0, tl_reg};
            gtm_pkg::REG_SPEED:     prdata = {27'd0, spd_reg};
            default:                prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dz_reg  <= gtm_pkg::DEAD_ZONE_RST;
            tl_reg  <= gtm_pkg::TRIG_LVL_RST;
            spd_reg <= gtm_pkg::SPEED_RST;
        end
        else
        begin
            dz_reg  <= dz_next;
            tl_reg  <= tl_next;
            spd_reg <= spd_next;
        end
    end

    gtm_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    gtm_datapath u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .stat           (stat),
        .opcode         (opcode),
        .stick_x        (stick_x),
        .stick_y        (stick_y),
        .trigger_left   (trigger_left),
        .trigger_right  (trigger_right),
        .flag           (flag),
        .dead_zone      (dz_reg),
        .trigger_level  (tl_reg),
        .speed          (spd_reg),
        .out_ready      (out_ready),
        .out_valid      (out_valid),
        .event_kind     (event_kind),
        .button_id      (button_id),
        .button_pressed (button_pressed),
        .move_x         (move_x),
        .move_y         (move_y),
        .scroll_amount  (scroll_amount),
        .next_delay_ms  (next_delay_ms),
        .last           (last)
    );

`ifndef SYNTHESIS
    // One item at a time: an accepted item blocks the input for the next cycle
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("input taken while previous item in progress");

    // Pointer moves always carry a clamped delay
    a_move_delay: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && event_kind == gtm_pkg::EV_MOVE) |->
        (next_delay_ms >= gtm_pkg::DELAY_MIN && next_delay_ms <= gtm_pkg::DELAY_MAX))
        else $error("move delay out of range");

    // Only a button pair can leave a result that is not the final one
    a_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !last) |-> (event_kind == gtm_pkg::EV_BUTTON))
        else $error("non-final result is not a button item");
`endif

endmodule
